// ----- hdl/hgd_pkg.sv -----
`timescale 1ns / 1ps
package hgd_pkg;

  // Field types
  typedef logic signed [23:0] coord_t;
  typedef logic signed [25:0] time_t;
  typedef logic signed [23:0] noise_t;
  typedef logic        [9:0]  pidx_t;
  typedef logic        [17:0] chan_t;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_GRID_MIN_X  = 3'd0;
  localparam logic [2:0] REG_GRID_MAX_X  = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE_X = 3'd2;
  localparam logic [2:0] REG_GRID_MIN_Y  = 3'd3;
  localparam logic [2:0] REG_GRID_MAX_Y  = 3'd4;
  localparam logic [2:0] REG_CELL_SIZE_Y = 3'd5;
  localparam logic [2:0] REG_TIME_UNC    = 3'd6;
  localparam logic [2:0] REG_TIME_BIN    = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_GRID_MIN = 24'd0;
  localparam logic [23:0] RST_GRID_MAX = 24'd8388607;
  localparam logic [19:0] RST_CELL     = 20'd256;

  // Binning gate: bin when width * BIN_GATE exceeds the uncertainty
  localparam logic [26:0] BIN_GATE = 27'd100;

  // Highest legal pixel index and channel number
  localparam logic [27:0] IDX_MAX  = 28'd1023;
  localparam logic [19:0] CHAN_MAX = 20'd262143;

  // Divider geometry
  localparam int unsigned DIV_DW  = 20;
  localparam int unsigned DIV1_NW = 26;

  // Snap range flags
  typedef struct packed {
    logic below;
    logic above;
  } rng_t;

  // Data carried alongside the pixel location stages
  typedef struct packed {
    logic signed [24:0] base_x;
    logic signed [24:0] base_y;
    rng_t               rng_x;
    rng_t               rng_y;
    logic signed [26:0] t_bin;
    logic signed [26:0] t_raw;
  } side2_t;

endpackage

// ----- hdl/hgd_hit_if.sv -----
`timescale 1ns / 1ps
interface hgd_hit_if;
  logic            valid;
  logic            ready;
  hgd_pkg::coord_t x_pos;
  hgd_pkg::coord_t y_pos;
  hgd_pkg::time_t  hit_time;
  hgd_pkg::noise_t time_noise;

  modport source (output valid, x_pos, y_pos, hit_time, time_noise, input ready);
  modport sink   (input valid, x_pos, y_pos, hit_time, time_noise, output ready);
endinterface

// ----- hdl/hgd_res_if.sv -----
`timescale 1ns / 1ps
interface hgd_res_if;
  logic            valid;
  logic            ready;
  hgd_pkg::coord_t x_snapped;
  hgd_pkg::coord_t y_snapped;
  hgd_pkg::time_t  time_out;
  hgd_pkg::pidx_t  pixel_row_index;
  hgd_pkg::pidx_t  pixel_col_index;
  hgd_pkg::chan_t  channel_number;
  logic            hit_valid;

  modport source (output valid, x_snapped, y_snapped, time_out, pixel_row_index,
                  pixel_col_index, channel_number, hit_valid, input ready);
  modport sink   (input valid, x_snapped, y_snapped, time_out, pixel_row_index,
                  pixel_col_index, channel_number, hit_valid, output ready);
endinterface

// ----- hdl/hgd_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, NW stages.
module hgd_div #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 20,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_q[k]   <= {nq_in[NW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ----- hdl/hit_grid_digitizer_channel_map.sv -----
`timescale 1ns / 1ps
// Hit grid digitizer with sensor-tile channel map.
// hit_i takes one photon hit per transaction (x, y, time, time noise sample);
// res_o returns one result per hit: snapped x and y, smeared and binned time,
// pixel row and column and the readout channel, or hit_valid low for a hit
// in a tile gap or out of index range.
// Configuration is written over the APB port at byte address 4 * index; it
// must only be changed while no hit is in flight.
// Stages from the accepting edge to res_o.valid: one input
// register, a 26-stage divider level (cell x, cell y and time bin division
// in parallel), four stages of tile and pixel location by reciprocal
// multiplication, one index stage and the output register.
// Throughput: one hit per cycle. The whole pipeline advances together; it
// stops only while the output register holds a result that res_o has not
// taken, and then hit_i.ready is low. Nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the register defaults.
module hit_grid_digitizer_channel_map #(
  parameter int unsigned TILE_PITCH    = 14848,
  parameter int unsigned TILE_SIZE     = 13568,
  parameter int unsigned PIXEL_WIDTH   = 1536,
  parameter int unsigned PIXEL_SPACING = 128,
  parameter int unsigned TILES_PER_ROW = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hgd_hit_if.sink     hit_i,
  hgd_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hgd_pkg::*;

  localparam logic [19:0]        PitchDen = 20'(TILE_PITCH);
  localparam logic signed [21:0] Spacing  = 22'(PIXEL_SPACING);
  localparam logic [20:0]        TileSize = 21'(TILE_SIZE);
  localparam logic [6:0]         TilesRow = 7'(TILES_PER_ROW);
  // reciprocals for the constant divisions, exact for 24 and 21 bit numerators
  localparam int unsigned        ShT      = 24 + $clog2(TILE_PITCH);
  localparam int unsigned        ShS      = 21 + $clog2(PIXEL_WIDTH + PIXEL_SPACING);
  localparam logic [63:0]        RecT64   = ((64'd1 << ShT) + 64'(TILE_PITCH) - 64'd1)
                                            / 64'(TILE_PITCH);
  localparam logic [63:0]        RecS64   = ((64'd1 << ShS)
                                            + 64'(PIXEL_WIDTH + PIXEL_SPACING) - 64'd1)
                                            / 64'(PIXEL_WIDTH + PIXEL_SPACING);
  localparam logic [24:0]        RecT     = RecT64[24:0];
  localparam logic [21:0]        RecS     = RecS64[21:0];

  // ---------------------------------------------------------------- config
  logic [23:0] min_x_q, max_x_q, min_y_q, max_y_q, unc_q;
  logic [19:0] cell_x_q, cell_y_q, bw_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= RST_GRID_MIN;
      max_x_q  <= RST_GRID_MAX;
      cell_x_q <= RST_CELL;
      min_y_q  <= RST_GRID_MIN;
      max_y_q  <= RST_GRID_MAX;
      cell_y_q <= RST_CELL;
      unc_q    <= '0;
      bw_q     <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GRID_MIN_X:  min_x_q  <= pwdata[23:0];
        REG_GRID_MAX_X:  max_x_q  <= pwdata[23:0];
        REG_CELL_SIZE_X: cell_x_q <= pwdata[19:0];
        REG_GRID_MIN_Y:  min_y_q  <= pwdata[23:0];
        REG_GRID_MAX_Y:  max_y_q  <= pwdata[23:0];
        REG_CELL_SIZE_Y: cell_y_q <= pwdata[19:0];
        REG_TIME_UNC:    unc_q    <= pwdata[23:0];
        REG_TIME_BIN:    bw_q     <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GRID_MIN_X:  prdata = {8'b0, min_x_q};
      REG_GRID_MAX_X:  prdata = {8'b0, max_x_q};
      REG_CELL_SIZE_X: prdata = {12'b0, cell_x_q};
      REG_GRID_MIN_Y:  prdata = {8'b0, min_y_q};
      REG_GRID_MAX_Y:  prdata = {8'b0, max_y_q};
      REG_CELL_SIZE_Y: prdata = {12'b0, cell_y_q};
      REG_TIME_UNC:    prdata = {8'b0, unc_q};
      REG_TIME_BIN:    prdata = {12'b0, bw_q};
      default:         prdata = '0;
    endcase
  end

  // zero cell size counts as one
  logic [19:0] cs_x, cs_y, h_x, h_y, h_t;
  logic        bin_en;
  assign cs_x   = (cell_x_q == '0) ? 20'd1 : cell_x_q;
  assign cs_y   = (cell_y_q == '0) ? 20'd1 : cell_y_q;
  assign h_x    = {1'b0, cs_x[19:1]};
  assign h_y    = {1'b0, cs_y[19:1]};
  assign h_t    = {1'b0, bw_q[19:1]};
  assign bin_en = (({7'b0, bw_q} * BIN_GATE) > {3'b0, unc_q}) && (bw_q != '0);

  // ------------------------------------------------------ pipeline advance
  logic out_vld_q, en;
  assign en          = !out_vld_q || res_o.ready;
  assign hit_i.ready = en;

  // ---------------------------------------------------------- input stage
  logic   in_vld_q;
  coord_t x_q, y_q;
  time_t  ht_q;
  noise_t tn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= hit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= hit_i.x_pos;
      y_q  <= hit_i.y_pos;
      ht_q <= hit_i.hit_time;
      tn_q <= hit_i.time_noise;
    end
  end

  // Numerators for the divider level
  logic signed [24:0] dx, dy;
  logic signed [26:0] t_sum, at;
  rng_t               rng_x0, rng_y0;

  assign dx     = {x_q[23], x_q} - {min_x_q[23], min_x_q};
  assign dy     = {y_q[23], y_q} - {min_y_q[23], min_y_q};
  assign rng_x0 = '{below: (x_q < $signed(min_x_q)), above: (x_q > $signed(max_x_q))};
  assign rng_y0 = '{below: (y_q < $signed(min_y_q)), above: (y_q > $signed(max_y_q))};
  assign t_sum  = {ht_q[25], ht_q} + {{3{tn_q[23]}}, tn_q};
  assign at     = t_sum[26] ? -t_sum : t_sum;

  // -------------------------------------------------------- divider level
  logic               v_sx, v_sy, v_t;
  logic [DIV1_NW-1:0] q_sx, q_sy, q_t;
  logic [DIV_DW-1:0]  r_sx, r_sy, r_t;
  logic [25:0]        sx_side, sy_side;
  rng_t               rng_x1, rng_y1;
  logic [26:0]        t_side;
  coord_t             x1, y1;

  hgd_div #(.NW(DIV1_NW), .DW(DIV_DW), .SW(26)) u_div_sx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_vld_q),
    .num_i({2'b0, dx[23:0]}), .den_i(cs_x), .side_i({rng_x0, x_q}),
    .valid_o(v_sx), .quo_o(q_sx), .rem_o(r_sx), .side_o(sx_side)
  );

  hgd_div #(.NW(DIV1_NW), .DW(DIV_DW), .SW(26)) u_div_sy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_vld_q),
    .num_i({2'b0, dy[23:0]}), .den_i(cs_y), .side_i({rng_y0, y_q}),
    .valid_o(v_sy), .quo_o(q_sy), .rem_o(r_sy), .side_o(sy_side)
  );

  hgd_div #(.NW(DIV1_NW), .DW(DIV_DW), .SW(27)) u_div_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_vld_q),
    .num_i(at[25:0]), .den_i(bw_q), .side_i({t_sum[26], at[25:0]}),
    .valid_o(v_t), .quo_o(q_t), .rem_o(r_t), .side_o(t_side)
  );

  assign rng_x1 = sx_side[25:24];
  assign x1     = sx_side[23:0];
  assign rng_y1 = sy_side[25:24];
  assign y1     = sy_side[23:0];

  // Snap base and time bin base
  side2_t      s2_in;
  logic        t_neg;
  logic [25:0] t_mag;

  assign t_neg = t_side[26];
  assign t_mag = t_side[25:0];

  always_comb begin
    s2_in.base_x = {x1[23], x1} - {5'b0, r_sx};
    s2_in.base_y = {y1[23], y1} - {5'b0, r_sy};
    s2_in.rng_x  = rng_x1;
    s2_in.rng_y  = rng_y1;
    s2_in.t_bin  = t_neg ? ({7'b0, r_t} - {1'b0, t_mag}) : ({1'b0, t_mag} - {7'b0, r_t});
    s2_in.t_raw  = t_neg ? -{1'b0, t_mag} : {1'b0, t_mag};
  end

  // ------------------------------------------------ pixel location stages
  logic   b_vld_q [4];
  side2_t b_s_q   [4];
  logic   pix_ok  [2];
  pidx_t  pix_idx [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) b_vld_q[i] <= 1'b0;
    end else if (en) begin
      b_vld_q[0] <= v_t;
      for (int i = 1; i < 4; i++) b_vld_q[i] <= b_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_s_q[0] <= s2_in;
      for (int i = 1; i < 4; i++) b_s_q[i] <= b_s_q[i-1];
    end
  end

  // tile by reciprocal, offset in tile, pixel within tile by reciprocal
  for (genvar a = 0; a < 2; a++) begin : g_axis
    coord_t             c;
    logic [23:0]        mag, mag_b1_q, qd;
    logic               neg_b1_q, neg_b2_q;
    logic [48:0]        prt_b1_q;
    logic [16:0]        qt, qt_b2_q;
    logic [19:0]        rem_b2_q;
    logic signed [21:0] sn, am;
    logic signed [17:0] tile, tile_b3_q, tile_b4_q;
    logic               gap_b3_q, gap_b4_q, sneg_b3_q, sneg_b4_q;
    logic [20:0]        am_b3_q, qs;
    logic [42:0]        prs_b4_q;
    logic signed [21:0] sub;
    logic signed [27:0] idx;

    assign c   = (a == 0) ? x1 : y1;
    assign mag = c[23] ? -c : c;

    // stage 1: magnitude times the pitch reciprocal
    always_ff @(posedge clk_i) begin
      if (en) begin
        prt_b1_q <= 49'(mag) * 49'(RecT);
        mag_b1_q <= mag;
        neg_b1_q <= c[23];
      end
    end

    // stage 2: tile magnitude and remainder inside the tile
    assign qt = 17'(prt_b1_q >> ShT);
    assign qd = {7'b0, qt} * {4'b0, PitchDen};

    always_ff @(posedge clk_i) begin
      if (en) begin
        qt_b2_q  <= qt;
        rem_b2_q <= 20'(mag_b1_q - qd);
        neg_b2_q <= neg_b1_q;
      end
    end

    // stage 3: offset takes the sign of the coordinate, plus the spacing
    assign tile = neg_b2_q ? -$signed({1'b0, qt_b2_q}) : $signed({1'b0, qt_b2_q});
    assign sn   = neg_b2_q ? (Spacing - {2'b0, rem_b2_q}) : (Spacing + {2'b0, rem_b2_q});
    assign am   = sn[21] ? -sn : sn;

    always_ff @(posedge clk_i) begin
      if (en) begin
        tile_b3_q <= tile;
        gap_b3_q  <= !neg_b2_q && ({1'b0, rem_b2_q} > TileSize);
        sneg_b3_q <= sn[21];
        am_b3_q   <= am[20:0];
      end
    end

    // stage 4: offset magnitude times the pixel pitch reciprocal
    always_ff @(posedge clk_i) begin
      if (en) begin
        prs_b4_q  <= 43'(am_b3_q) * 43'(RecS);
        tile_b4_q <= tile_b3_q;
        gap_b4_q  <= gap_b3_q;
        sneg_b4_q <= sneg_b3_q;
      end
    end

    assign qs  = 21'(prs_b4_q >> ShS);
    assign sub = sneg_b4_q ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    assign idx = {{7{tile_b4_q[17]}}, tile_b4_q, 3'b000} + {{6{sub[21]}}, sub};

    assign pix_ok[a]  = !gap_b4_q && !idx[27] && (idx <= $signed(IDX_MAX));
    assign pix_idx[a] = idx[9:0];
  end

  // Final snap and time
  logic signed [25:0] xv, yv;
  logic signed [27:0] tv;
  coord_t             xs, ys;
  time_t              tf;

  always_comb begin
    if (b_s_q[3].rng_x.below)      xv = {{2{min_x_q[23]}}, min_x_q} - {6'b0, h_x};
    else if (b_s_q[3].rng_x.above) xv = {{2{max_x_q[23]}}, max_x_q} + {6'b0, h_x};
    else                           xv = {b_s_q[3].base_x[24], b_s_q[3].base_x} + {6'b0, h_x};
    if (b_s_q[3].rng_y.below)      yv = {{2{min_y_q[23]}}, min_y_q} - {6'b0, h_y};
    else if (b_s_q[3].rng_y.above) yv = {{2{max_y_q[23]}}, max_y_q} + {6'b0, h_y};
    else                           yv = {b_s_q[3].base_y[24], b_s_q[3].base_y} + {6'b0, h_y};
  end

  // saturate to the field range
  assign xs = (xv[25:23] == 3'b000 || xv[25:23] == 3'b111) ? xv[23:0]
            : (xv[25] ? 24'sh800000 : 24'sh7fffff);
  assign ys = (yv[25:23] == 3'b000 || yv[25:23] == 3'b111) ? yv[23:0]
            : (yv[25] ? 24'sh800000 : 24'sh7fffff);

  assign tv = bin_en ? ({b_s_q[3].t_bin[26], b_s_q[3].t_bin} + {8'b0, h_t})
                     : {b_s_q[3].t_raw[26], b_s_q[3].t_raw};
  assign tf = (tv[27:25] == 3'b000 || tv[27:25] == 3'b111) ? tv[25:0]
            : (tv[27] ? 26'sh2000000 : 26'sh1ffffff);

  // ----------------------------------------------------------- index stage
  logic   p_vld_q, p_ok_q;
  coord_t p_xs_q, p_ys_q;
  time_t  p_t_q;
  pidx_t  p_xi_q, p_yi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= b_vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xs_q <= xs;
      p_ys_q <= ys;
      p_t_q  <= tf;
      p_xi_q <= pix_idx[0];
      p_yi_q <= pix_idx[1];
      p_ok_q <= pix_ok[0] && pix_ok[1];
    end
  end

  // Channel: tile id times 64 plus column-in-tile times 8 plus row-in-tile
  logic [13:0] tile_id;
  logic [19:0] ch;
  logic        ok_f;

  assign tile_id = {7'b0, p_xi_q[9:3]} + ({7'b0, p_yi_q[9:3]} * {7'b0, TilesRow});
  assign ch      = {tile_id, p_yi_q[2:0], p_xi_q[2:0]};
  assign ok_f    = p_ok_q && (ch <= CHAN_MAX);

  // ------------------------------------------------------- output register
  coord_t o_xs_q, o_ys_q;
  time_t  o_t_q;
  pidx_t  o_xi_q, o_yi_q;
  chan_t  o_ch_q;
  logic   o_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_xs_q <= p_xs_q;
      o_ys_q <= p_ys_q;
      o_t_q  <= p_t_q;
      o_xi_q <= ok_f ? p_xi_q : '0;
      o_yi_q <= ok_f ? p_yi_q : '0;
      o_ch_q <= ok_f ? ch[17:0] : '0;
      o_ok_q <= ok_f;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.x_snapped       = o_xs_q;
  assign res_o.y_snapped       = o_ys_q;
  assign res_o.time_out        = o_t_q;
  assign res_o.pixel_row_index = o_xi_q;
  assign res_o.pixel_col_index = o_yi_q;
  assign res_o.channel_number  = o_ch_q;
  assign res_o.hit_valid       = o_ok_q;

  // ------------------------------------------------------------ assertions
  // divider lanes stay aligned
  a_lvl1_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_sx == v_t) && (v_sy == v_t))
    else $error("divider lanes out of step");

  // a result not taken stays on the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> out_vld_q)
    else $error("result transaction dropped while stalled");

  // an invalid hit carries zero indexes and channel
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !o_ok_q) |-> (o_xi_q == '0 && o_yi_q == '0 && o_ch_q == '0))
    else $error("invalid hit with nonzero pixel or channel");

  // a stall keeps the index stage item in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && p_vld_q) |=> p_vld_q)
    else $error("index stage transaction lost during stall");

endmodule

// ----- tb/sv/hgd_checker.sv -----
`timescale 1ns / 1ps
module hgd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hgd_hit_if.sink     hit_i,
  hgd_res_if.sink     res_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  import hgd_pkg::*;

  localparam longint TILE_PITCH    = 14848;
  localparam longint TILE_SIZE     = 13568;
  localparam longint PIXEL_WIDTH   = 1536;
  localparam longint PIXEL_SPACING = 128;
  localparam longint TILES_PER_ROW = 18;
  localparam longint CHAN_PER_TILE = 64;
  localparam longint PIX_SIDE      = 8;

  typedef struct {
    coord_t x_snapped;
    coord_t y_snapped;
    time_t  time_out;
    pidx_t  row;
    pidx_t  col;
    chan_t  chan;
    logic   hit_valid;
  } digi_t;

  // Shadow copy of the register file
  longint min_x, max_x, cell_x, min_y, max_y, cell_y, t_unc, t_bin;
  digi_t  digi_q[$];
  int     fails;

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint grid_snap(longint c, longint lo, longint hi, longint sz);
    longint cs;
    cs = (sz == 0) ? 1 : sz;
    if (c < lo) return clip(lo - cs / 2, 24);
    if (c > hi) return clip(hi + cs / 2, 24);
    return clip(cs * ((c - lo) / cs) + lo + cs / 2, 24);
  endfunction

  // Pixel index along one axis; returns 0 for a tile gap or index out of range
  function automatic bit pixel_of(longint c, output longint idx);
    longint tile, off, sub;
    tile = c / TILE_PITCH;
    off  = c - tile * TILE_PITCH;
    sub  = (off + PIXEL_SPACING) / (PIXEL_WIDTH + PIXEL_SPACING);
    idx  = tile * PIX_SIDE + sub;
    if (off > TILE_SIZE) return 0;
    return idx >= 0 && idx <= 1023;
  endfunction

  function automatic digi_t digitize(coord_t x, coord_t y, time_t ht, noise_t nz);
    digi_t  d;
    longint t, xi, yi, ch;
    bit     ok, oky;
    t = longint'(ht) + longint'(nz);
    d.x_snapped = coord_t'(grid_snap(longint'(x), min_x, max_x, cell_x));
    d.y_snapped = coord_t'(grid_snap(longint'(y), min_y, max_y, cell_y));
    if (t_bin * 100 > t_unc && t_bin != 0) t = (t / t_bin) * t_bin + t_bin / 2;
    d.time_out = time_t'(clip(t, 26));
    ok  = pixel_of(longint'(x), xi);
    oky = pixel_of(longint'(y), yi);
    ok  = ok && oky;
    ch  = 0;
    if (ok) begin
      ch = (xi / PIX_SIDE + (yi / PIX_SIDE) * TILES_PER_ROW) * CHAN_PER_TILE
           + (yi % PIX_SIDE) * PIX_SIDE + xi % PIX_SIDE;
      if (ch > 262143) ok = 0;
    end
    if (!ok) begin
      xi = 0; yi = 0; ch = 0;
    end
    d.row = pidx_t'(xi);
    d.col = pidx_t'(yi);
    d.chan = chan_t'(ch);
    d.hit_valid = ok;
    return d;
  endfunction

  function automatic longint sx24(logic [31:0] v);
    return longint'(signed'(v[23:0]));
  endfunction

  // Register writes, hit predictions and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    digi_t e;
    if (!rst_ni) begin
      min_x = 0; max_x = 8388607; cell_x = 256;
      min_y = 0; max_y = 8388607; cell_y = 256;
      t_unc = 0; t_bin = 0;
      digi_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_GRID_MIN_X:  min_x  = sx24(pwdata);
          REG_GRID_MAX_X:  max_x  = sx24(pwdata);
          REG_CELL_SIZE_X: cell_x = longint'(pwdata[19:0]);
          REG_GRID_MIN_Y:  min_y  = sx24(pwdata);
          REG_GRID_MAX_Y:  max_y  = sx24(pwdata);
          REG_CELL_SIZE_Y: cell_y = longint'(pwdata[19:0]);
          REG_TIME_UNC:    t_unc  = longint'(pwdata[23:0]);
          REG_TIME_BIN:    t_bin  = longint'(pwdata[19:0]);
          default: ;
        endcase
      end
      if (hit_i.valid && hit_i.ready)
        digi_q.push_back(digitize(hit_i.x_pos, hit_i.y_pos, hit_i.hit_time, hit_i.time_noise));
      if (res_i.valid && res_i.ready) begin
        if (digi_q.size() == 0) begin
          fails++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          e = digi_q.pop_front();
          if ({res_i.x_snapped, res_i.y_snapped, res_i.time_out, res_i.pixel_row_index,
               res_i.pixel_col_index, res_i.channel_number, res_i.hit_valid} !==
              {e.x_snapped, e.y_snapped, e.time_out, e.row, e.col, e.chan, e.hit_valid}) begin
            fails++;
            $display("%0t: mismatch exp x=%0d y=%0d t=%0d row=%0d col=%0d ch=%0d v=%0b",
                     $time, e.x_snapped, e.y_snapped, e.time_out, e.row, e.col, e.chan,
                     e.hit_valid);
            $display("%0t:          got x=%0d y=%0d t=%0d row=%0d col=%0d ch=%0d v=%0b",
                     $time, res_i.x_snapped, res_i.y_snapped, res_i.time_out,
                     res_i.pixel_row_index, res_i.pixel_col_index, res_i.channel_number,
                     res_i.hit_valid);
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = digi_q.size();
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import hgd_pkg::*;

  localparam int LATENCY = 32;
  localparam int LIMIT   = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          snd_idle = 0, rcv_idle = 0;
  int          hold_off = 0;
  logic        hold_req = 1'b0;
  int          cycles = 0;

  hgd_hit_if hit ();
  hgd_res_if res ();

  initial begin
    hit.valid = 1'b0; hit.x_pos = '0; hit.y_pos = '0;
    hit.hit_time = '0; hit.time_noise = '0;
    res.ready = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hit_grid_digitizer_channel_map dut (
    .clk_i(clk), .rst_ni(rst_n), .hit_i(hit.sink), .res_o(res.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hgd_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .hit_i(hit.sink), .res_i(res.sink),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** hit_grid_digitizer_channel_map: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_off <= 300;
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= rst_n && ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_grid(int mnx, int mxx, int cx, int mny, int mxy, int cy,
                          int unc, int bin);
    reg_write(REG_GRID_MIN_X, mnx);
    reg_write(REG_GRID_MAX_X, mxx);
    reg_write(REG_CELL_SIZE_X, cx);
    reg_write(REG_GRID_MIN_Y, mny);
    reg_write(REG_GRID_MAX_Y, mxy);
    reg_write(REG_CELL_SIZE_Y, cy);
    reg_write(REG_TIME_UNC, unc);
    reg_write(REG_TIME_BIN, bin);
  endtask

  task automatic send_hit(int x, int y, int t, int n);
    bit acc;
    while ($urandom_range(99) < snd_idle) begin
      hit.valid <= 1'b0;
      @(posedge clk);
    end
    hit.valid <= 1'b1;
    hit.x_pos <= coord_t'(x); hit.y_pos <= coord_t'(y);
    hit.hit_time <= time_t'(t); hit.time_noise <= noise_t'(n);
    do begin
      @(negedge clk);
      acc = hit.ready;
      @(posedge clk);
    end while (!acc);
  endtask

  // Wait for every expected transaction, then let the pipeline drain
  task automatic drain();
    hit.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(16777215) - 8388608;
      2:       return $urandom_range(2200000) - 100000;
      default: return $urandom_range(300000) - 20000;
    endcase
  endfunction

  task automatic random_hits(int count);
    for (int i = 0; i < count; i++)
      send_hit(pick_coord(), pick_coord(), $urandom_range(67108863) - 33554432,
               ($urandom_range(3) == 0) ? $urandom_range(16777215) - 8388608
                                        : $urandom_range(2000) - 1000);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: corners, tile gap, index limit, time saturation
    send_hit(0, 0, 0, 0);
    send_hit(8388607, 8388607, 33554431, 8388607);
    send_hit(-8388608, -8388608, -33554432, -8388608);
    send_hit(-1, 5, 100, -100);
    send_hit(13600, 14000, 77, 3);
    send_hit(13568, 13569, 1, 1);
    send_hit(127 * 14848 + 7 * 1664, 127 * 14848 + 7 * 1664, 9, 9);
    send_hit(128 * 14848, 5000, 9, 9);
    send_hit(14848 * 17 + 200, 14848 * 5 + 1700, -5, 5);
    send_hit(-14848, 300, 33554431, 1);
    drain();

    // Widest cells, single-unit y cells, binning on
    set_grid(-8388608, 8388607, 1048575, -1000, 200000, 1, 0, 1048575);
    send_hit(8388607, -1001, 33554431, 8388607);
    send_hit(-8388608, 200001, -33554432, -8388608);
    send_hit(12345, 199999, -1048577, 0);
    send_hit(-3, -1000, 1048574, 1);
    snd_idle = 25; rcv_idle = 69;
    random_hits(150);
    hold_req <= 1'b1;
    random_hits(150);
    drain();

    // Cell size zero, inverted y limits, binning gated off
    set_grid(1000, 50000, 0, 8388607, -8388608, 333, 16777215, 100);
    send_hit(1000, 0, 12345, 1);
    send_hit(50001, 8388607, -12345, -1);
    snd_idle = 69; rcv_idle = 25;
    random_hits(250);
    drain();

    // Random settings, small bins, then no idling
    set_grid($urandom_range(200000) - 100000, $urandom_range(400000), $urandom_range(5000) + 1,
             $urandom_range(200000) - 100000, $urandom_range(400000), $urandom_range(5000) + 1,
             1000, 5000);
    send_hit(-7, 7, -7499, 0);
    send_hit(7, -7, 7499, 0);
    snd_idle = 0; rcv_idle = 0;
    random_hits(150);
    drain();
    set_grid($urandom_range(16777215) - 8388608, 8388607, $urandom_range(1048575),
             -8388608, $urandom_range(16777215) - 8388608, $urandom_range(1048575),
             $urandom_range(16777215), $urandom_range(1048575));
    random_hits(220);
    drain();

    if (fail_count == 0) begin
      $display("** hit_grid_digitizer_channel_map: PASSED **");
    end else begin
      $display("** hit_grid_digitizer_channel_map: FAILED **");
    end
    $finish;
  end
endmodule
